// ===== sv/cpes_pkg.sv =====
package cpes_pkg;

   localparam int FracBits = 16;
   localparam int CordicSteps = 16;

   localparam logic [31:0] CGrav   = 32'd164416717;
   localparam logic [31:0] CPml    = 32'd838861;
   localparam logic [31:0] CInvTm  = 32'd15252015;
   localparam logic [31:0] CPmlTm  = 32'd762601;
   localparam logic [31:0] CHalf43 = 32'd11184811;
   localparam logic [31:0] CTau    = 32'd335544;
   localparam logic [31:0] CNpos   = 32'd167772;
   localparam logic [31:0] CNang   = 32'd16777;
   localparam logic [31:0] CXlim   = 32'd40265318;
   localparam logic [31:0] CAlim   = 32'd3513793;
   localparam logic [31:0] CTurn   = 32'd683565276;
   localparam logic [31:0] CPiQ30  = 32'd3373259426;
   localparam logic [31:0] CGain   = 32'd652032874;

   localparam logic [1:0] REG_START_POS  = 2'd0;
   localparam logic [1:0] REG_START_VEL  = 2'd1;
   localparam logic [1:0] REG_START_ANG  = 2'd2;
   localparam logic [1:0] REG_START_RATE = 2'd3;

   localparam logic OP_STEP   = 1'b0;
   localparam logic OP_RELOAD = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic               push_right;
      logic signed [15:0] noise_position;
      logic signed [15:0] noise_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] angle;
      logic signed [31:0] angular_rate;
      logic               failed;
   } rsp_type;

   // multiplier command: product of a and b, shifted right by sh (floor)
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic [5:0]         sh;
   } mul_cmd_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 32'd843314856;
         5'd1: atan_q30 = 32'd497837829;
         5'd2: atan_q30 = 32'd263043836;
         5'd3: atan_q30 = 32'd133525158;
         5'd4: atan_q30 = 32'd67021686;
         5'd5: atan_q30 = 32'd33543515;
         5'd6: atan_q30 = 32'd16775850;
         5'd7: atan_q30 = 32'd8388437;
         5'd8: atan_q30 = 32'd4194282;
         5'd9: atan_q30 = 32'd2097149;
         5'd10: atan_q30 = 32'd1048575;
         5'd11: atan_q30 = 32'd524287;
         5'd12: atan_q30 = 32'd262143;
         5'd13: atan_q30 = 32'd131071;
         5'd14: atan_q30 = 32'd65535;
         5'd15: atan_q30 = 32'd32767;
         5'd16: atan_q30 = 32'd16383;
         5'd17: atan_q30 = 32'd8191;
         5'd18: atan_q30 = 32'd4095;
         5'd19: atan_q30 = 32'd2047;
         5'd20: atan_q30 = 32'd1023;
         5'd21: atan_q30 = 32'd511;
         5'd22: atan_q30 = 32'd255;
         5'd23: atan_q30 = 32'd127;
         default: atan_q30 = 32'd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) sat32 = 32'h7FFF_FFFF;
      else if (v < -66'sd2147483648) sat32 = 32'h8000_0000;
      else sat32 = v[31:0];
   endfunction

endpackage

// ===== sv/cart_pole_euler_step_unit.sv =====
// Channel  Dir  Handshake        Payload
// req      in   req_valid/ready  cpes_pkg::req_type
// rsp      out  rsp_valid/ready  cpes_pkg::rsp_type
// csr      in   csr_we           csr_index, csr_wdata
//
// A step beat runs the two phase multiplies, the CORDIC rotations, 16 multiplies
// through the one shared multiplier, a bit-serial divide (start, quotient bits,
// done) and the flag state. A reload beat goes straight to the flag state, which
// raises rsp_valid. After either, the block passes through S_OUT back to idle.
// Synchronous active-high reset clears state and start registers to zero.
// req_ready is high only in the idle state; the result sits in a register
// until rsp_ready takes it, and the next beat is accepted after that.
module cart_pole_euler_step_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpes_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpes_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PHASE = 4'd1;  // angle to turn fraction
   localparam logic [3:0] S_ZMAP  = 4'd2;  // rest to Q2.30 angle
   localparam logic [3:0] S_CORD  = 4'd3;  // rotations
   localparam logic [3:0] S_MUL   = 4'd4;  // multiply sequence
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_MUL2  = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_FAIL  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;    // CORDIC index or multiply-sequence step
   logic       wait_ff, wait_in;    // multiplier result pending

   logic signed [31:0] pos_ff, pos_in, vel_ff, vel_in, ang_ff, ang_in, rate_ff, rate_in;
   logic signed [31:0] st_ff [4];
   cpes_pkg::req_type  req_ff;
   cpes_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;

   logic [1:0]         quad_ff, quad_in;
   logic [31:0]        rest_ff, rest_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [31:0] s_ff, s_in, c_ff, c_in;
   // scratch registers for the multiply chain
   logic signed [31:0] td2_ff, td2_in, tmp_ff, tmp_in, num_ff, num_in;
   logic signed [31:0] den_ff, den_in, tha_ff, tha_in, xa_ff, xa_in, t_ff, t_in;
   logic signed [65:0] acc_ff, acc_in;

   cpes_pkg::mul_cmd_type mcmd;
   logic signed [65:0]    m_sh;
   logic signed [31:0]    m_sat;
   logic                  dstart, ddone;
   logic signed [31:0]    dquo;
   logic signed [33:0]    dx, dy, cxc, cyc;
   logic signed [31:0]    fpos, fang;

   cpes_mul u_mul (.clock(clock), .cmd(mcmd), .prod_sh(m_sh), .prod_sat(m_sat));
   cpes_div u_div (.clock(clock), .reset(reset), .start(dstart), .num(num_ff),
                   .den(den_ff), .done(ddone), .quo(dquo));

   assign req_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;
   assign cxc = (cx_ff > 34'sd1073741824) ? 34'sd1073741824 :
                (cx_ff < -34'sd1073741824) ? -34'sd1073741824 : cx_ff;
   assign cyc = (cy_ff > 34'sd1073741824) ? 34'sd1073741824 :
                (cy_ff < -34'sd1073741824) ? -34'sd1073741824 : cy_ff;

   function automatic logic signed [32:0] sx(input logic signed [31:0] v);
      sx = 33'(v);
   endfunction

   // multiplier operands for the phase, angle-map and multiply-sequence states
   always_comb begin
      mcmd = '{a: '0, b: '0, sh: '0};
      unique case (state_ff)
         S_PHASE: mcmd = '{a: sx(ang_ff), b: {1'b0, cpes_pkg::CTurn}, sh: 6'(cpes_pkg::FracBits)};
         S_ZMAP:  mcmd = '{a: {1'b0, rest_ff}, b: {1'b0, cpes_pkg::CPiQ30}, sh: 6'd31};
         S_MUL: begin
            case (step_ff)
               5'd0:  mcmd = '{a: sx(rate_ff), b: sx(rate_ff), sh: 6'(cpes_pkg::FracBits)};
               5'd1:  mcmd = '{a: sx(td2_ff), b: sx(s_ff), sh: 6'd30};
               5'd2:  mcmd = '{a: sx(t_ff), b: {1'b0, cpes_pkg::CPml}, sh: 6'd24};
               5'd3:  mcmd = '{a: sx(tmp_ff), b: {1'b0, cpes_pkg::CInvTm}, sh: 6'd24};
               5'd4:  mcmd = '{a: sx(s_ff), b: {1'b0, cpes_pkg::CGrav},
                               sh: 6'(54 - cpes_pkg::FracBits)};
               5'd5:  mcmd = '{a: sx(c_ff), b: sx(tmp_ff), sh: 6'd30};
               5'd6:  mcmd = '{a: sx(c_ff), b: sx(c_ff), sh: 6'd30};
               5'd7:  mcmd = '{a: {1'b0, cpes_pkg::CPmlTm}, b: sx(t_ff), sh: 6'd30};
               default: mcmd = '{a: '0, b: '0, sh: '0};
            endcase
         end
         S_MUL2: begin
            case (step_ff)
               5'd0: mcmd = '{a: sx(tha_ff), b: sx(c_ff), sh: 6'd30};
               5'd1: mcmd = '{a: sx(t_ff), b: {1'b0, cpes_pkg::CPmlTm}, sh: 6'd24};
               5'd2: mcmd = '{a: sx(vel_ff), b: {1'b0, cpes_pkg::CTau}, sh: 6'd24};
               5'd3: mcmd = '{a: sx(32'(req_ff.noise_position)), b: {1'b0, cpes_pkg::CNpos},
                              sh: 6'(36 - cpes_pkg::FracBits)};
               5'd4: mcmd = '{a: sx(xa_ff), b: {1'b0, cpes_pkg::CTau}, sh: 6'd24};
               5'd5: mcmd = '{a: sx(rate_ff), b: {1'b0, cpes_pkg::CTau}, sh: 6'd24};
               5'd6: mcmd = '{a: sx(32'(req_ff.noise_angle)), b: {1'b0, cpes_pkg::CNang},
                              sh: 6'(36 - cpes_pkg::FracBits)};
               5'd7: mcmd = '{a: sx(tha_ff), b: {1'b0, cpes_pkg::CTau}, sh: 6'd24};
               default: mcmd = '{a: '0, b: '0, sh: '0};
            endcase
         end
         default: mcmd = '{a: '0, b: '0, sh: '0};
      endcase
   end

   assign fpos = 32'(cpes_pkg::CXlim >> (24 - cpes_pkg::FracBits));
   assign fang = 32'(cpes_pkg::CAlim >> (24 - cpes_pkg::FracBits));

   always_comb begin
      state_in = state_ff; step_in = step_ff; wait_in = 1'b0;
      pos_in = pos_ff; vel_in = vel_ff; ang_in = ang_ff; rate_in = rate_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff;
      quad_in = quad_ff; rest_in = rest_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; s_in = s_ff; c_in = c_ff;
      td2_in = td2_ff; tmp_in = tmp_ff; num_in = num_ff; den_in = den_ff;
      tha_in = tha_ff; xa_in = xa_ff; t_in = t_ff; acc_in = acc_ff;
      dstart = 1'b0;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.opcode == cpes_pkg::OP_RELOAD) begin
                  pos_in = st_ff[cpes_pkg::REG_START_POS];
                  vel_in = st_ff[cpes_pkg::REG_START_VEL];
                  ang_in = st_ff[cpes_pkg::REG_START_ANG];
                  rate_in = st_ff[cpes_pkg::REG_START_RATE];
                  state_in = S_FAIL;
               end else begin
                  state_in = S_PHASE;
               end
               wait_in = 1'b0;
            end
         end
         S_PHASE, S_ZMAP: begin
            wait_in = !wait_ff;
            if (wait_ff) begin
               if (state_ff == S_PHASE) begin
                  quad_in = m_sh[31:30];
                  rest_in = {2'b00, m_sh[29:0]};
                  state_in = S_ZMAP;
               end else begin
                  cz_in = 34'(m_sh);
                  cx_in = 34'(cpes_pkg::CGain); cy_in = '0;
                  step_in = '0; state_in = S_CORD;
               end
            end
         end
         S_CORD: begin
            if (step_ff < 5'(cpes_pkg::CordicSteps) && step_ff < 5'd24) begin
               if (!cz_ff[33]) begin
                  cx_in = cx_ff - dx; cy_in = cy_ff + dy;
                  cz_in = cz_ff - 34'(cpes_pkg::atan_q30(step_ff));
               end else begin
                  cx_in = cx_ff + dx; cy_in = cy_ff - dy;
                  cz_in = cz_ff + 34'(cpes_pkg::atan_q30(step_ff));
               end
               step_in = step_ff + 5'd1;
            end else begin
               case (quad_ff)
                  2'd0: begin s_in = 32'(cyc);  c_in = 32'(cxc);  end
                  2'd1: begin s_in = 32'(cxc);  c_in = 32'(-cyc); end
                  2'd2: begin s_in = 32'(-cyc); c_in = 32'(-cxc); end
                  default: begin s_in = 32'(-cxc); c_in = 32'(cyc); end
               endcase
               step_in = '0; state_in = S_MUL;
            end
         end
         S_MUL: begin
            wait_in = !wait_ff;
            if (wait_ff) begin
               step_in = step_ff + 5'd1;
               case (step_ff)
                  5'd0: td2_in = m_sat;
                  5'd1: t_in = m_sat;
                  5'd2: begin
                     tmp_in = cpes_pkg::sat32(66'(req_ff.push_right ?
                        (34'sd10 <<< cpes_pkg::FracBits) : -(34'sd10 <<< cpes_pkg::FracBits))
                        + 66'(m_sat));
                  end
                  5'd3: tmp_in = m_sat;
                  5'd4: t_in = m_sat;
                  5'd5: num_in = cpes_pkg::sat32(66'(t_ff) - 66'(m_sat));
                  5'd6: t_in = 32'(m_sh);
                  default: begin
                     den_in = 32'(66'(cpes_pkg::CHalf43) - m_sh);
                     dstart = 1'b0;
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (!wait_ff) begin
               dstart = 1'b1; wait_in = 1'b1;
            end else if (ddone) begin
               tha_in = dquo; step_in = '0; state_in = S_MUL2;
            end else begin
               wait_in = 1'b1;
            end
         end
         S_MUL2: begin
            wait_in = !wait_ff;
            if (wait_ff) begin
               step_in = step_ff + 5'd1;
               case (step_ff)
                  5'd0: t_in = m_sat;
                  5'd1: xa_in = cpes_pkg::sat32(66'(tmp_ff) - 66'(m_sat));
                  5'd2: acc_in = 66'(pos_ff) + 66'(m_sat);
                  5'd3: pos_in = cpes_pkg::sat32(acc_ff + m_sh);
                  5'd4: vel_in = cpes_pkg::sat32(66'(vel_ff) + 66'(m_sat));
                  5'd5: acc_in = 66'(ang_ff) + 66'(m_sat);
                  5'd6: ang_in = cpes_pkg::sat32(acc_ff + m_sh);
                  default: begin
                     rate_in = cpes_pkg::sat32(66'(rate_ff) + 66'(m_sat));
                     state_in = S_FAIL;
                  end
               endcase
            end
         end
         S_FAIL: begin
            rsp_in.position = pos_ff; rsp_in.velocity = vel_ff;
            rsp_in.angle = ang_ff; rsp_in.angular_rate = rate_ff;
            rsp_in.failed = (pos_ff < -fpos) || (pos_ff > fpos) ||
                            (ang_ff < -fang) || (ang_ff > fang);
            rspv_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= '0; wait_ff <= 1'b0; rspv_ff <= 1'b0;
         pos_ff <= '0; vel_ff <= '0; ang_ff <= '0; rate_ff <= '0;
         for (int i = 0; i < 4; i++) st_ff[i] <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; wait_ff <= wait_in;
         rspv_ff <= rspv_in;
         pos_ff <= pos_in; vel_ff <= vel_in; ang_ff <= ang_in; rate_ff <= rate_in;
         if (csr_we) st_ff[csr_index] <= csr_wdata;
      end
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff <= rsp_in;
      quad_ff <= quad_in; rest_ff <= rest_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; s_ff <= s_in; c_ff <= c_in;
      td2_ff <= td2_in; tmp_ff <= tmp_in; num_ff <= num_in; den_ff <= den_in;
      tha_ff <= tha_in; xa_ff <= xa_in; t_ff <= t_in; acc_ff <= acc_in;
   end

`ifndef SYNTH
   // no new beat while a result waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   // divider only runs in its state
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      dstart |-> state_ff == S_DIV) else $error("divider start outside divide");
   // the result register only loads from the flag state
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_FAIL) else $error("stray result");
`endif
endmodule

// ===== sv/cpes_mul.sv =====
// Shared multiplier: 33x33 signed product, registered, then shift and saturate.
module cpes_mul (
   input  logic                  clock,
   input  cpes_pkg::mul_cmd_type cmd,
   output logic signed [65:0]    prod_sh,
   output logic signed [31:0]    prod_sat
);
   logic signed [65:0] prod_ff, prod_in;
   logic [5:0]         sh_ff, sh_in;

   assign prod_in = 66'(cmd.a) * 66'(cmd.b);
   assign sh_in   = cmd.sh;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
   end

   assign prod_sh  = prod_ff >>> sh_ff;
   assign prod_sat = cpes_pkg::sat32(prod_sh);
endmodule

// ===== sv/cpes_div.sv =====
// Restoring divider, one quotient bit per cycle; truncates toward zero, saturates.
module cpes_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);
   // |num|*2^24 < 2^56 ; quotient up to 56 bits
   logic [55:0] dvd_ff, dvd_in;
   logic [55:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] nabs;
   logic signed [57:0] qs;

   assign nabs = num[31] ? 32'(-num) : 32'(num);
   assign trial = {rem_ff, dvd_ff[55]} - {1'b0, den_ff};

   always_comb begin
      dvd_in = dvd_ff; q_in = q_ff; rem_in = rem_ff; den_in = den_ff;
      neg_in = neg_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         dvd_in = {nabs, 24'd0};
         q_in = '0; rem_in = '0; den_in = den; neg_in = num[31];
         cnt_in = 6'd56; busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[54:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            q_in = {q_ff[54:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], dvd_ff[55]};
            q_in = {q_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; q_ff <= q_in; rem_ff <= rem_in;
      den_ff <= den_in; neg_ff <= neg_in;
   end

   assign qs   = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
   assign quo  = cpes_pkg::sat32(66'(qs));
   assign done = done_ff;
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   // watchdog: limit covers a step beat plus the longest receiver stall
   localparam int WatchdogLimit = 4000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   cpes_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   cpes_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [31:0]       csr_wdata;

   cart_pole_euler_step_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // Plant predictor: own copy of the start registers and the state
   // ---------------------------------------------------------------
   logic signed [31:0] start_regs [4];
   logic signed [63:0] plant_pos, plant_vel, plant_ang, plant_rate;
   cpes_pkg::rsp_type  expected_states [$];
   int                 error_count;
   int                 idle_cycles;
   int                 stall_left;
   bit                 timed_out;

   localparam longint Q30One = 64'sd1073741824;
   localparam longint AtanTab [24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

   // >>> on a signed longint is a floor shift
   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fix_mul(input longint a, input longint b, input int sh);
      return clip32((a * b) >>> sh);
   endfunction

   function automatic longint clip_unit(input longint v);
      if (v > Q30One) return Q30One;
      if (v < -Q30One) return -Q30One;
      return v;
   endfunction

   task automatic pole_sin_cos(input longint theta, output longint s, output longint c);
      logic [63:0] prod;
      logic [31:0] phase;
      logic [1:0]  quad;
      logic [63:0] rest;
      longint      x, y, z, dx, dy;
      prod  = 64'(theta) * 64'(cpes_pkg::CTurn);
      phase = prod[cpes_pkg::FracBits +: 32];
      quad  = phase[31:30];
      rest  = {34'd0, phase[29:0]};
      x = longint'(cpes_pkg::CGain);
      y = 0;
      z = longint'((rest * 64'(cpes_pkg::CPiQ30)) >> 31);
      for (int i = 0; i < cpes_pkg::CordicSteps && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= AtanTab[i];
         end else begin
            x += dx; y -= dy; z += AtanTab[i];
         end
      end
      x = clip_unit(x);
      y = clip_unit(y);
      case (quad)
         2'd0: begin s = y;  c = x;  end
         2'd1: begin s = x;  c = -y; end
         2'd2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endtask

   task automatic predict_plant(input cpes_pkg::req_type beat);
      longint s, c, force_v, td2, temp, num, c2, den, thacc, xacc;
      longint np, na, xl, al;
      cpes_pkg::rsp_type r;
      if (beat.opcode == cpes_pkg::OP_RELOAD) begin
         plant_pos  = start_regs[cpes_pkg::REG_START_POS];
         plant_vel  = start_regs[cpes_pkg::REG_START_VEL];
         plant_ang  = start_regs[cpes_pkg::REG_START_ANG];
         plant_rate = start_regs[cpes_pkg::REG_START_RATE];
      end else begin
         np = beat.noise_position;
         na = beat.noise_angle;
         force_v = 64'sd10 <<< cpes_pkg::FracBits;
         if (!beat.push_right) force_v = -force_v;
         pole_sin_cos(plant_ang, s, c);
         td2   = fix_mul(plant_rate, plant_rate, cpes_pkg::FracBits);
         temp  = clip32(force_v +
                        fix_mul(fix_mul(td2, s, 30), longint'(cpes_pkg::CPml), 24));
         temp  = fix_mul(temp, longint'(cpes_pkg::CInvTm), 24);
         num   = clip32(fix_mul(s, longint'(cpes_pkg::CGrav), 54 - cpes_pkg::FracBits) -
                        fix_mul(c, temp, 30));
         c2    = (c * c) >>> 30;
         den   = longint'(cpes_pkg::CHalf43) - ((longint'(cpes_pkg::CPmlTm) * c2) >>> 30);
         thacc = clip32((num * 64'sd16777216) / den);
         xacc  = clip32(temp - fix_mul(fix_mul(thacc, c, 30),
                                       longint'(cpes_pkg::CPmlTm), 24));
         // all updates use the pre-step state
         begin
            longint nx, nv, nth, ntd;
            nx  = clip32(plant_pos + fix_mul(plant_vel, longint'(cpes_pkg::CTau), 24) +
                         ((np * longint'(cpes_pkg::CNpos)) >>> (36 - cpes_pkg::FracBits)));
            nv  = clip32(plant_vel + fix_mul(xacc, longint'(cpes_pkg::CTau), 24));
            nth = clip32(plant_ang + fix_mul(plant_rate, longint'(cpes_pkg::CTau), 24) +
                         ((na * longint'(cpes_pkg::CNang)) >>> (36 - cpes_pkg::FracBits)));
            ntd = clip32(plant_rate + fix_mul(thacc, longint'(cpes_pkg::CTau), 24));
            plant_pos = nx; plant_vel = nv; plant_ang = nth; plant_rate = ntd;
         end
      end
      xl = longint'(cpes_pkg::CXlim) >>> (24 - cpes_pkg::FracBits);
      al = longint'(cpes_pkg::CAlim) >>> (24 - cpes_pkg::FracBits);
      r.position     = plant_pos[31:0];
      r.velocity     = plant_vel[31:0];
      r.angle        = plant_ang[31:0];
      r.angular_rate = plant_rate[31:0];
      r.failed       = (plant_pos < -xl || plant_pos > xl ||
                        plant_ang < -al || plant_ang > al);
      expected_states.push_back(r);
   endtask

   // mostly short gaps, a few long, some stretches with none
   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------
   // Driver side
   // ---------------------------------------------------------------
   task automatic send_beat(input cpes_pkg::req_type beat);
      // valid goes low between beats
      repeat (gap_len() + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      predict_plant(beat);
      req_valid <= 1'b0;
   endtask

   // only while idle: every expected beat drained, plus slack for the pipeline
   task automatic write_start(input logic [1:0] idx, input logic [31:0] value);
      while (expected_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      start_regs[idx] = value;
      csr_we <= 1'b0;
   endtask

   task automatic load_start(input logic [31:0] p, input logic [31:0] v,
                             input logic [31:0] a, input logic [31:0] r);
      write_start(cpes_pkg::REG_START_POS, p);
      write_start(cpes_pkg::REG_START_VEL, v);
      write_start(cpes_pkg::REG_START_ANG, a);
      write_start(cpes_pkg::REG_START_RATE, r);
   endtask

   function automatic cpes_pkg::req_type step_beat(input bit right, input logic [15:0] np,
                                                   input logic [15:0] na);
      cpes_pkg::req_type b;
      b.opcode = cpes_pkg::OP_STEP;
      b.push_right = right;
      b.noise_position = np;
      b.noise_angle = na;
      return b;
   endfunction

   function automatic cpes_pkg::req_type reload_beat();
      cpes_pkg::req_type b;
      b = cpes_pkg::req_type'({$urandom(), 2'($urandom())});
      b.opcode = cpes_pkg::OP_RELOAD;
      return b;
   endfunction

   // small uniform noise (-4096 to 4095) mostly, full range sometimes
   function automatic logic [15:0] noise_sample();
      if ($urandom_range(0, 9) == 0) return 16'($urandom());
      return 16'($signed($urandom_range(0, 8191)) - 4096);
   endfunction

   // ---------------------------------------------------------------
   // Receiver side: random back-pressure and the compare
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected beat %p", $time, rsp_data);
               error_count++;
            end else begin
               cpes_pkg::rsp_type e;
               e = expected_states.pop_front();
               if (rsp_data.position !== e.position) begin
                  $display("%0t: position exp %0d got %0d", $time, e.position,
                           rsp_data.position);
                  error_count++;
               end
               if (rsp_data.velocity !== e.velocity) begin
                  $display("%0t: velocity exp %0d got %0d", $time, e.velocity,
                           rsp_data.velocity);
                  error_count++;
               end
               if (rsp_data.angle !== e.angle) begin
                  $display("%0t: angle exp %0d got %0d", $time, e.angle, rsp_data.angle);
                  error_count++;
               end
               if (rsp_data.angular_rate !== e.angular_rate) begin
                  $display("%0t: angular_rate exp %0d got %0d", $time, e.angular_rate,
                           rsp_data.angular_rate);
                  error_count++;
               end
               if (rsp_data.failed !== e.failed) begin
                  $display("%0t: failed exp %0b got %0b", $time, e.failed, rsp_data.failed);
                  error_count++;
               end
            end
         end
         // ready low for a random stall, then a fresh draw
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            int g;
            g = gap_len();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready  <= 1'b0;
               stall_left <= g - 1;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_reset_state();
      // first step from the all-zero plant, both pushes
      send_beat(step_beat(1'b1, 16'h0000, 16'h0000));
      send_beat(step_beat(1'b0, 16'h0000, 16'h0000));
      send_beat(reload_beat());
   endtask

   task automatic test_noise_extremes();
      send_beat(step_beat(1'b1, 16'h7FFF, 16'h7FFF));
      send_beat(step_beat(1'b0, 16'h8000, 16'h8000));
      send_beat(step_beat(1'b1, 16'hFFFF, 16'h0001));
      send_beat(step_beat(1'b0, 16'h5555, 16'hAAAA));
   endtask

   task automatic test_saturation();
      // every start register at the top, then the bottom
      load_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(reload_beat());
      send_beat(step_beat(1'b1, 16'h7FFF, 16'h7FFF));
      send_beat(step_beat(1'b1, 16'h7FFF, 16'h7FFF));
      load_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_beat(reload_beat());
      send_beat(step_beat(1'b0, 16'h8000, 16'h8000));
      send_beat(step_beat(1'b0, 16'h8000, 16'h8000));
   endtask

   task automatic test_failure_edges();
      // exactly on the limits (not failed), one lsb beyond (failed)
      load_start(32'(cpes_pkg::CXlim >> (24 - cpes_pkg::FracBits)), 32'd0,
                 32'(cpes_pkg::CAlim >> (24 - cpes_pkg::FracBits)), 32'd0);
      send_beat(reload_beat());
      write_start(cpes_pkg::REG_START_POS,
                  -32'sd1 - 32'(cpes_pkg::CXlim >> (24 - cpes_pkg::FracBits)));
      write_start(cpes_pkg::REG_START_ANG,
                  -32'sd1 - 32'(cpes_pkg::CAlim >> (24 - cpes_pkg::FracBits)));
      send_beat(reload_beat());
      // large angles that wrap for the trig only
      load_start(32'd0, 32'd0, 32'sd205887, 32'sd65536);
      send_beat(reload_beat());
      send_beat(step_beat(1'b1, 16'h0000, 16'h0000));
      write_start(cpes_pkg::REG_START_ANG, 32'sd411775);
      send_beat(reload_beat());
      send_beat(step_beat(1'b0, 16'h0000, 16'h0000));
      write_start(cpes_pkg::REG_START_ANG, -32'sd308831);
      send_beat(reload_beat());
      send_beat(step_beat(1'b1, 16'h0000, 16'h0000));
   endtask

   task automatic test_random_episodes(input int beat_budget);
      int sent;
      int ep_len;
      sent = 0;
      while (sent < beat_budget) begin
         if ($urandom_range(0, 3) == 0) begin
            // new start state: mostly plausible, sometimes any value
            if ($urandom_range(0, 4) == 0)
               load_start($urandom(), $urandom(), $urandom(), $urandom());
            else
               load_start(32'($signed($urandom_range(0, 262143)) - 131072),
                          32'($signed($urandom_range(0, 131071)) - 65536),
                          32'($signed($urandom_range(0, 20000)) - 10000),
                          32'($signed($urandom_range(0, 131071)) - 65536));
         end
         send_beat(reload_beat());
         sent++;
         ep_len = $urandom_range(5, 60);
         for (int k = 0; k < ep_len && sent < beat_budget; k++) begin
            send_beat(step_beat(1'($urandom_range(0, 1)), noise_sample(), noise_sample()));
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = cpes_pkg::REG_START_POS;
      csr_wdata   = '0;
      error_count = 0;
      timed_out   = 1'b0;
      plant_pos = 0; plant_vel = 0; plant_ang = 0; plant_rate = 0;
      for (int i = 0; i < 4; i++) start_regs[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_noise_extremes();
      test_saturation();
      test_failure_edges();
      test_random_episodes(1380);

      while (expected_states.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cpes_pkg.sv
sv/cpes_mul.sv
sv/cpes_div.sv
sv/cart_pole_euler_step_unit.sv
sim/tb_top.sv
